// ===== sv/gble_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the gap-buffer line editor.
// Used by gble_res_fifo and gap_buffer_line_editor_unit; depends on nothing.
package gble_pkg;

    localparam int FieldW     = 6;  // width of text_length and cursor_pos
    localparam int FifoDepth  = 4;
    localparam int FifoPtrW   = 2;
    localparam int FifoCountW = 3;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_BACKSPACE = 3'd1,
        CMD_LEFT      = 3'd2,
        CMD_RIGHT     = 3'd3,
        CMD_READ      = 3'd4,
        CMD_CLEAR     = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_BOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_READ
    } t_state;

    typedef struct packed {
        logic [7:0]        char_out;
        logic              char_valid;
        logic              last_result;
        t_status           status;
        logic [FieldW-1:0] text_length;
        logic [FieldW-1:0] cursor_pos;
    } t_result;

endpackage

// ===== sv/gap_buffer_line_editor_unit.sv =====
`timescale 1ns / 1ps
// Gap-buffer line editor: text store in one synchronous RAM, gap pointers in flops.
// Insert, backspace, clear, refused and unused commands: result queued at accept.
// Cursor left/right: RAM read, then write back of the moved character (held while the queue is full).
// Read out: after accept, one character per cycle while the result queue has room, limited by the
// single RAM read port; the next item is taken once the last character has landed.
// Reset (synchronous, active low) empties the line and the result queue; the store is not swept.
module gap_buffer_line_editor_unit #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_in
    input  logic [2:0]  i_s_tuser,   // [2:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] char_out, [9:8] status, [15:10] text_length,
                                     // [21:16] cursor_pos, [23:22] zero
    output logic        o_m_tuser,   // [0] char_valid
    output logic        o_m_tlast    // last_result
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

    logic [7:0]  r_store [DEPTH];
    logic [7:0]  r_rd_data;

    gble_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_gap_first, n_gap_first;
    logic [AW-1:0] r_gap_last,  n_gap_last;
    logic [AW-1:0] r_count,     n_count;
    logic [AW-1:0] r_addr,      n_addr;
    logic [AW-1:0] r_remain,    n_remain;
    logic          r_move_left, n_move_left;
    logic          r_rd_vld,    n_rd_vld;
    logic          r_rd_last,   n_rd_last;

    logic          s_accept;
    gble_pkg::t_cmd cmd;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;
    logic          edit_push;
    gble_pkg::t_status edit_status;
    logic          fifo_push, fifo_full;
    logic [gble_pkg::FifoCountW-1:0] fifo_count;
    gble_pkg::t_result fifo_in, fifo_out;
    logic [AW-1:0] addr_inc;

    assign cmd        = gble_pkg::t_cmd'(i_s_tuser);
    assign o_s_tready = (r_state == gble_pkg::S_IDLE) && !r_rd_vld && !fifo_full;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign addr_inc   = r_addr + 1'b1;

    // Text store: one write and one registered read per cycle. Reads and writes never
    // target the same cycle, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_store[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gble_pkg::S_IDLE;
            r_gap_first <= '0;
            r_gap_last  <= LastIdx;
            r_count     <= '0;
            r_addr      <= '0;
            r_remain    <= '0;
            r_move_left <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gap_first <= n_gap_first;
            r_gap_last  <= n_gap_last;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_remain    <= n_remain;
            r_move_left <= n_move_left;
            r_rd_vld    <= n_rd_vld;
            r_rd_last   <= n_rd_last;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_gap_first = r_gap_first;
        n_gap_last  = r_gap_last;
        n_count     = r_count;
        n_addr      = r_addr;
        n_remain    = r_remain;
        n_move_left = r_move_left;
        n_rd_vld    = 1'b0;
        n_rd_last   = r_rd_last;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_gap_first;
        mem_raddr   = r_addr;
        mem_wdata   = i_s_tdata;
        edit_push   = 1'b0;
        edit_status = gble_pkg::ST_DONE;

        unique case (r_state)
            gble_pkg::S_IDLE: begin
                if (s_accept) begin
                    case (cmd)
                        gble_pkg::CMD_INSERT: begin
                            edit_push = 1'b1;
                            if (r_gap_first == r_gap_last) begin
                                edit_status = gble_pkg::ST_FULL;
                            end else begin
                                mem_we      = 1'b1;
                                n_gap_first = r_gap_first + 1'b1;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        gble_pkg::CMD_BACKSPACE: begin
                            edit_push = 1'b1;
                            if (r_gap_first == '0) begin
                                edit_status = gble_pkg::ST_BOUND;
                            end else begin
                                n_gap_first = r_gap_first - 1'b1;
                                n_count     = r_count - 1'b1;
                            end
                        end
                        gble_pkg::CMD_LEFT: begin
                            if (r_gap_first == '0) begin
                                edit_push   = 1'b1;
                                edit_status = gble_pkg::ST_BOUND;
                            end else begin
                                mem_re      = 1'b1;
                                mem_raddr   = r_gap_first - 1'b1;
                                n_move_left = 1'b1;
                                n_state     = gble_pkg::S_MOVE;
                            end
                        end
                        gble_pkg::CMD_RIGHT: begin
                            if (r_gap_last == LastIdx) begin
                                edit_push   = 1'b1;
                                edit_status = gble_pkg::ST_BOUND;
                            end else begin
                                mem_re      = 1'b1;
                                mem_raddr   = r_gap_last + 1'b1;
                                n_move_left = 1'b0;
                                n_state     = gble_pkg::S_MOVE;
                            end
                        end
                        gble_pkg::CMD_READ: begin
                            if (r_count == '0) begin
                                edit_push = 1'b1;
                            end else begin
                                // start at the right part when nothing lies left of the gap
                                n_addr   = (r_gap_first == '0) ? r_gap_last + 1'b1 : '0;
                                n_remain = r_count;
                                n_state  = gble_pkg::S_READ;
                            end
                        end
                        gble_pkg::CMD_CLEAR: begin
                            edit_push   = 1'b1;
                            n_gap_first = '0;
                            n_gap_last  = LastIdx;
                            n_count     = '0;
                        end
                        default: begin
                            edit_push = 1'b1;
                        end
                    endcase
                end
            end
            gble_pkg::S_MOVE: begin
                // write the moved character across the gap, then shift the gap
                if (!fifo_full) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data;
                    edit_push = 1'b1;
                    n_state   = gble_pkg::S_IDLE;
                    if (r_move_left) begin
                        mem_waddr   = r_gap_last;
                        n_gap_first = r_gap_first - 1'b1;
                        n_gap_last  = r_gap_last - 1'b1;
                    end else begin
                        mem_waddr   = r_gap_first;
                        n_gap_first = r_gap_first + 1'b1;
                        n_gap_last  = r_gap_last + 1'b1;
                    end
                end
            end
            gble_pkg::S_READ: begin
                // issue only when the queue has room for every read still in flight
                if ((4'(fifo_count) + 4'(r_rd_vld)) < 4'(gble_pkg::FifoDepth)) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr;
                    n_rd_vld  = 1'b1;
                    n_rd_last = (r_remain == AW'(1));
                    n_remain  = r_remain - 1'b1;
                    n_addr    = (addr_inc == r_gap_first) ? r_gap_last + 1'b1 : addr_inc;
                    if (r_remain == AW'(1)) begin
                        n_state = gble_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = gble_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (r_rd_vld) begin
            fifo_in.char_out    = r_rd_data;
            fifo_in.char_valid  = 1'b1;
            fifo_in.last_result = r_rd_last;
            fifo_in.status      = gble_pkg::ST_DONE;
            fifo_in.text_length = gble_pkg::FieldW'(r_count);
            fifo_in.cursor_pos  = gble_pkg::FieldW'(r_gap_first);
        end else begin
            fifo_in.char_out    = 8'd0;
            fifo_in.char_valid  = 1'b0;
            fifo_in.last_result = 1'b1;
            fifo_in.status      = edit_status;
            fifo_in.text_length = gble_pkg::FieldW'(n_count);
            fifo_in.cursor_pos  = gble_pkg::FieldW'(n_gap_first);
        end
    end

    assign fifo_push = r_rd_vld || edit_push;

    gble_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (fifo_in),
        .i_pop   (i_m_tready),
        .o_data  (fifo_out),
        .o_valid (o_m_tvalid),
        .o_full  (fifo_full),
        .o_count (fifo_count)
    );

    assign o_m_tdata = {2'b00, fifo_out.cursor_pos, fifo_out.text_length,
                        fifo_out.status, fifo_out.char_out};
    assign o_m_tuser = fifo_out.char_valid;
    assign o_m_tlast = fifo_out.last_result;

`ifndef SYNTH
    a_count_matches_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (7'(r_count) + 7'(r_gap_last)) == (7'(r_gap_first) + 7'(LastIdx)))
        else $error("character count disagrees with gap pointers");

    a_gap_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_first <= r_gap_last)
        else $error("gap start passed gap end");

    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_push |-> (!fifo_full || i_m_tready))
        else $error("result pushed into full queue");

    a_read_last_ends_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && r_rd_last) |-> (r_state == gble_pkg::S_IDLE))
        else $error("final read beat while read still running");
`endif

endmodule

// ===== sv/gble_res_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue between the editor core and the output stream.
// Depends on gble_pkg for the result type and queue depth.
module gble_res_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  gble_pkg::t_result                   i_data,
    input  logic                                i_pop,
    output gble_pkg::t_result                   o_data,
    output logic                                o_valid,
    output logic                                o_full,
    output logic [gble_pkg::FifoCountW-1:0]     o_count
);

    gble_pkg::t_result                  r_mem [gble_pkg::FifoDepth];
    logic [gble_pkg::FifoPtrW-1:0]      r_wr_ptr;
    logic [gble_pkg::FifoPtrW-1:0]      r_rd_ptr;
    logic [gble_pkg::FifoCountW-1:0]    r_count;
    logic                               do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == gble_pkg::FifoCountW'(gble_pkg::FifoDepth));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for gap_buffer_line_editor_unit: key beats in, line results out.
// Depends on gble_pkg (command, status and result types) and the unit itself.
module testbench;

    localparam int LineDepth = 64;
    localparam int CycleLimit = 2000000;
    localparam logic [2:0] CmdSpareA = 3'd6;
    localparam logic [2:0] CmdSpareB = 3'd7;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] ch;
    } t_key_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;    // [7:0] char_in
    logic [2:0]  i_s_tuser = 3'd0;    // [2:0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;           // [7:0] char_out, [9:8] status, [15:10] text_length,
                                      // [21:16] cursor_pos, [23:22] zero
    logic        o_m_tuser;           // [0] char_valid
    logic        o_m_tlast;           // last_result

    t_key_item key_queue[$];
    t_key_item next_key;
    gble_pkg::t_result line_results[$];
    gble_pkg::t_result want;

    // shadow line: gap occupies gap_lo..gap_hi, cursor at gap_lo
    logic [7:0] line_mem[LineDepth];
    logic [5:0] gap_lo = 6'd0;
    logic [5:0] gap_hi = 6'(LineDepth - 1);
    logic [5:0] line_len = 6'd0;

    int keys_total = 0;
    int edit_count = 0;
    int keys_accepted = 0;
    int beats_checked = 0;
    int mismatches = 0;
    int n_reads = 0;
    int n_full = 0;
    int n_bound = 0;
    int cycle_count = 0;
    int src_hold = 0;
    int sink_hold = 0;
    logic src_bursty = 1'b1;
    logic sink_bursty = 1'b1;

    gap_buffer_line_editor_unit #(
        .DEPTH(LineDepth)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] rand_cmd();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic void queue_key(logic [2:0] cmd, logic [7:0] ch);
        t_key_item k;
        k.cmd = cmd;
        k.ch = ch;
        key_queue.push_back(k);
        keys_total++;
        if (cmd <= gble_pkg::CMD_CLEAR) begin
            edit_count++;
        end
    endfunction

    function automatic void queue_result(logic [7:0] c, logic v, logic l,
                                         gble_pkg::t_status st);
        gble_pkg::t_result r;
        r.char_out = c;
        r.char_valid = v;
        r.last_result = l;
        r.status = st;
        r.text_length = line_len;
        r.cursor_pos = gap_lo;
        line_results.push_back(r);
    endfunction

    // Apply one key to the shadow line and queue the results it must produce.
    function automatic void predict_edit(logic [2:0] cmd, logic [7:0] ch);
        gble_pkg::t_status st;
        int total;
        int k;
        st = gble_pkg::ST_DONE;
        case (cmd)
            gble_pkg::CMD_INSERT: begin
                if (gap_lo == gap_hi) begin
                    st = gble_pkg::ST_FULL;
                end else begin
                    line_mem[gap_lo] = ch;
                    gap_lo++;
                    line_len++;
                end
            end
            gble_pkg::CMD_BACKSPACE: begin
                if (gap_lo == 0) begin
                    st = gble_pkg::ST_BOUND;
                end else begin
                    gap_lo--;
                    line_len--;
                end
            end
            gble_pkg::CMD_LEFT: begin
                if (gap_lo == 0) begin
                    st = gble_pkg::ST_BOUND;
                end else begin
                    line_mem[gap_hi] = line_mem[gap_lo - 1];
                    gap_lo--;
                    gap_hi--;
                end
            end
            gble_pkg::CMD_RIGHT: begin
                if (gap_hi == 6'(LineDepth - 1)) begin
                    st = gble_pkg::ST_BOUND;
                end else begin
                    line_mem[gap_lo] = line_mem[gap_hi + 1];
                    gap_lo++;
                    gap_hi++;
                end
            end
            gble_pkg::CMD_READ: begin
                n_reads++;
                total = int'(gap_lo) + (LineDepth - 1 - int'(gap_hi));
                if (total == 0) begin
                    queue_result(8'd0, 1'b0, 1'b1, gble_pkg::ST_DONE);
                    return;
                end
                k = 0;
                for (int i = 0; i < int'(gap_lo); i++) begin
                    k++;
                    queue_result(line_mem[i], 1'b1, k == total, gble_pkg::ST_DONE);
                end
                for (int i = int'(gap_hi) + 1; i < LineDepth; i++) begin
                    k++;
                    queue_result(line_mem[i], 1'b1, k == total, gble_pkg::ST_DONE);
                end
                return;
            end
            gble_pkg::CMD_CLEAR: begin
                gap_lo = 6'd0;
                gap_hi = 6'(LineDepth - 1);
                line_len = 6'd0;
            end
            default: begin
            end
        endcase
        if (st == gble_pkg::ST_FULL) n_full++;
        if (st == gble_pkg::ST_BOUND) n_bound++;
        queue_result(8'd0, 1'b0, 1'b1, st);
    endfunction

    task automatic check_field(string what, int exp_val, int act_val);
        if (exp_val != act_val) begin
            mismatches++;
            $display("[%0t] %s mismatch: expected %0h, actual %0h",
                     $time, what, exp_val, act_val);
        end
    endtask

    // One random run of keys: typing, cursor walks, erasing, reads, clears, noise.
    task automatic add_edit_run();
        int n;
        n = int'($urandom_range(1, 8));
        case ($urandom_range(0, 11))
            0, 1, 2: repeat (n + 2) queue_key(gble_pkg::CMD_INSERT, rand_byte());
            3: repeat ($urandom_range(20, 45)) queue_key(gble_pkg::CMD_INSERT, rand_byte());
            4, 5: repeat (n) queue_key(gble_pkg::CMD_LEFT, rand_byte());
            6: repeat (n) queue_key(gble_pkg::CMD_RIGHT, rand_byte());
            7: repeat ((n + 1) / 2) queue_key(gble_pkg::CMD_BACKSPACE, rand_byte());
            8, 9: queue_key(gble_pkg::CMD_READ, rand_byte());
            10: begin
                if ($urandom_range(0, 2) == 0) begin
                    queue_key(gble_pkg::CMD_CLEAR, rand_byte());
                end else begin
                    queue_key(gble_pkg::CMD_BACKSPACE, rand_byte());
                    queue_key(gble_pkg::CMD_INSERT, rand_byte());
                end
            end
            default: repeat ((n + 1) / 2) queue_key(rand_cmd(), rand_byte());
        endcase
    endtask

    // Source side: hold the beat until taken, then pick the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_hold <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_edit(i_s_tuser, i_s_tdata);
                keys_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_hold != 0) begin
                    src_hold <= src_hold - 1;
                    i_s_tvalid <= 1'b0;
                end else if (key_queue.size() != 0) begin
                    next_key = key_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser <= next_key.cmd;
                    i_s_tdata <= next_key.ch;
                    if (src_bursty && key_queue.size() > 40 && $urandom_range(0, 3) == 0) begin
                        src_hold <= int'($urandom_range(1, 14));
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random stalls in bursts, none near the end.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            i_m_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (sink_bursty && key_queue.size() > 40 && $urandom_range(0, 5) == 0) begin
                sink_hold <= int'($urandom_range(1, 14));
            end
        end
    end

    // Flip the idling on and off so that calm stretches occur too.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 48 == 0) begin
            src_bursty <= 1'($urandom_range(0, 1));
            sink_bursty <= 1'($urandom_range(0, 1));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            beats_checked++;
            if (line_results.size() == 0) begin
                mismatches++;
                $display("[%0t] unexpected result beat: expected none, actual data %0h",
                         $time, o_m_tdata);
            end else begin
                want = line_results.pop_front();
                check_field("char_out", int'(want.char_out), int'(o_m_tdata[7:0]));
                check_field("char_valid", int'(want.char_valid), int'(o_m_tuser));
                check_field("last_result", int'(want.last_result), int'(o_m_tlast));
                check_field("status", int'(want.status), int'(o_m_tdata[9:8]));
                check_field("text_length", int'(want.text_length), int'(o_m_tdata[15:10]));
                check_field("cursor_pos", int'(want.cursor_pos), int'(o_m_tdata[21:16]));
            end
        end
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("tb: failure");
        $finish;
    end

    initial begin
        // boundaries on an empty line, spare codes, then a short edit in the middle
        queue_key(gble_pkg::CMD_READ, 8'h00);
        queue_key(gble_pkg::CMD_BACKSPACE, 8'h00);
        queue_key(gble_pkg::CMD_LEFT, 8'hFF);
        queue_key(gble_pkg::CMD_RIGHT, 8'h00);
        queue_key(CmdSpareA, 8'h3C);
        queue_key(CmdSpareB, 8'hC3);
        queue_key(gble_pkg::CMD_INSERT, 8'h00);
        queue_key(gble_pkg::CMD_INSERT, 8'hFF);
        queue_key(gble_pkg::CMD_INSERT, 8'h5A);
        queue_key(gble_pkg::CMD_INSERT, 8'hA5);
        queue_key(gble_pkg::CMD_LEFT, 8'h00);
        queue_key(gble_pkg::CMD_LEFT, 8'h00);
        queue_key(gble_pkg::CMD_READ, 8'h00);
        queue_key(gble_pkg::CMD_INSERT, 8'h7E);
        queue_key(gble_pkg::CMD_BACKSPACE, 8'h00);
        queue_key(gble_pkg::CMD_RIGHT, 8'h00);
        queue_key(gble_pkg::CMD_RIGHT, 8'h00);
        queue_key(gble_pkg::CMD_RIGHT, 8'h00);
        queue_key(gble_pkg::CMD_LEFT, 8'h00);
        queue_key(gble_pkg::CMD_BACKSPACE, 8'h00);
        queue_key(gble_pkg::CMD_READ, 8'h00);
        queue_key(gble_pkg::CMD_CLEAR, 8'h00);
        queue_key(gble_pkg::CMD_READ, 8'h00);
        queue_key(gble_pkg::CMD_RIGHT, 8'h00);

        // fill the line past capacity, then edit around the full state
        queue_key(gble_pkg::CMD_CLEAR, rand_byte());
        repeat (LineDepth + 1) queue_key(gble_pkg::CMD_INSERT, rand_byte());
        queue_key(gble_pkg::CMD_READ, rand_byte());
        repeat (3) queue_key(gble_pkg::CMD_LEFT, rand_byte());
        queue_key(gble_pkg::CMD_INSERT, rand_byte());
        queue_key(gble_pkg::CMD_BACKSPACE, rand_byte());
        queue_key(gble_pkg::CMD_INSERT, rand_byte());
        queue_key(gble_pkg::CMD_READ, rand_byte());

        while (edit_count < 330) add_edit_run();
        queue_key(gble_pkg::CMD_READ, rand_byte());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (keys_accepted != keys_total) @(posedge i_clk);
        while (line_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d keys (%0d reads), checked %0d result beats;", keys_accepted,
                 n_reads, beats_checked);
        $display("full-line refusals %0d, cursor boundary hits %0d, mismatches %0d.",
                 n_full, n_bound, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/gble_pkg.sv
sv/gble_res_fifo.sv
sv/gap_buffer_line_editor_unit.sv
dv/testbench.sv
